FILE: hw/rtl/steq_pkg.sv
// Shared types and constants of the sorted timer event queue.
package steq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TAG_BITS_DEF    = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int ADDR_W          = 3;

	localparam logic [ADDR_W-3:0] REG_TICK_FREQUENCY = '0;
	localparam logic [31:0]       FREQ_RESET         = 32'd62500000;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_FIRED = 2'd1,
		KIND_ADDED = 2'd2,
		KIND_FULL  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_START,
		S_WALK,
		S_PLACE,
		S_TICK,
		S_CHECK,
		S_LOAD,
		S_RES
	} state_t;

endpackage

FILE: hw/rtl/sorted_timer_event_queue.sv
// Sorted timer event queue: tick counter, sorted deadline store and its sequencer.
//
// Requests arrive on in_valid/in_ready with cmd, timeout, by_tick and event_tag.
// A tick request (cmd 0) advances the 64-bit counter and pops every due head entry,
// giving one fired result each (at most 16), or one "nothing due" result.
// An add request (cmd 1) computes its expiry and inserts it behind equal deadlines,
// or answers "full". Results leave on out_valid/out_ready; last marks the final one.
// The user must write tick_frequency over the APB port at address 0 only while the
// block is idle, which the block itself does not enforce.
// in_ready is high only while the sequencer is idle; one request is worked at a time.
// An add request passes the multiplier (timeout in seconds only), adder, start,
// a walk over each entry later than the new expiry and the first one not later,
// placement and result. A tick request passes tick, compare and result when
// nothing is due; each fired result passes compare, head reload and result.
// The walk over the store goes one entry per cycle through one memory read port.
// The queue is a circular buffer; popping advances the head pointer.
// Reset empties the queue, clears the counter and loads the frequency reset value.
// A stalled receiver holds the output register; the sequencer then waits at its next
// result, and a new request may be taken while the last result is still held.
module sorted_timer_event_queue
	import steq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [31:0]       timeout,
	input  logic              by_tick,
	input  logic [15:0]       event_tag,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [15:0]       fired_tag,
	output logic [63:0]       fire_time,
	output logic [4:0]        queue_count,
	output logic [63:0]       next_deadline,
	output logic              armed,
	output logic              last,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
		return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
		return (i == '0) ? IW'(QUEUE_DEPTH - 1) : i - 1'b1;
	endfunction

	logic [63:0]       mem_dl  [QUEUE_DEPTH];
	logic [TAG_BITS-1:0] mem_tag [QUEUE_DEPTH];

	state_t            state_q, state_d;
	logic [63:0]       tick_now_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     head_ptr_q;
	logic [31:0]       freq_q;
	logic              out_valid_q;
	logic [NW-1:0]     n_q;

	logic [31:0]       timeout_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [63:0]       addend_q;
	logic [63:0]       expiry_q;
	logic [IW-1:0]     walk_idx_q;
	logic [IW-1:0]     place_q;
	kind_t             res_kind_q;
	logic [TAG_BITS-1:0] res_tag_q;
	logic [63:0]       res_time_q;
	logic [63:0]       head_dl_q;
	logic [TAG_BITS-1:0] head_tag_q;
	logic [63:0]       rd_dl_q;
	logic [TAG_BITS-1:0] rd_tag_q;

	kind_t             out_kind_q;
	logic [15:0]       out_tag_q;
	logic [63:0]       out_time_q;
	logic [4:0]        out_count_q;
	logic [63:0]       out_dl_q;
	logic              out_armed_q;
	logic              out_last_q;

	logic              in_acc;
	logic              cfg_wr;
	logic              reg_hit;
	logic [63:0]       mul_w;
	logic [63:0]       add_b;
	logic [63:0]       sum_w;
	logic [63:0]       cmp_x;
	logic [63:0]       cmp_y;
	logic              cmp_le;
	logic              due;
	logic              cont;
	logic              is_full;
	logic              out_free;
	logic              out_load;
	logic [IW:0]       tail_sum;
	logic [IW-1:0]     tail_idx;
	logic              mem_we;
	logic [IW-1:0]     mem_wa;
	logic [63:0]       mem_wdl;
	logic [TAG_BITS-1:0] mem_wtag;
	logic [IW-1:0]     rd_addr;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == REG_TICK_FREQUENCY);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? freq_q : '0;

	// single multiplier; adder and comparator shared between add and tick steps
	assign mul_w  = 64'(freq_q) * 64'(timeout_q);
	assign add_b  = (state_q == S_TICK) ? 64'd1 : addend_q;
	assign sum_w  = tick_now_q + add_b;
	assign cmp_x  = (state_q == S_WALK) ? rd_dl_q : head_dl_q;
	assign cmp_y  = (state_q == S_WALK) ? expiry_q : tick_now_q;
	assign cmp_le = (cmp_x <= cmp_y);

	assign due      = (count_q != '0) && cmp_le;
	assign cont     = (res_kind_q == KIND_FIRED) && (n_q != NW'(MAX_RESULTS)) && due;
	assign is_full  = (count_q == CW'(QUEUE_DEPTH));
	assign out_free = !out_valid_q || out_ready;

	assign tail_sum = (IW+1)'(head_ptr_q) + (IW+1)'(count_q) - 1'b1;
	assign tail_idx = (tail_sum >= (IW+1)'(QUEUE_DEPTH)) ?
		IW'(tail_sum - (IW+1)'(QUEUE_DEPTH)) : tail_sum[IW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (cmd) begin
						state_d = by_tick ? S_ADD : S_MUL;
					end else begin
						state_d = S_TICK;
					end
				end
			end
			S_MUL:   state_d = S_ADD;
			S_ADD:   state_d = S_START;
			S_START: begin
				if (is_full) begin
					state_d = S_RES;
				end else if (count_q == '0) begin
					state_d = S_PLACE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (cmp_le || (walk_idx_q == head_ptr_q)) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: state_d = S_RES;
			S_TICK:  state_d = S_CHECK;
			S_CHECK: state_d = (due && (n_q != NW'(MAX_RESULTS))) ? S_LOAD : S_RES;
			S_LOAD:  state_d = S_RES;
			S_RES: begin
				if (out_free) begin
					state_d = cont ? S_CHECK : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = place_q;
		mem_wdl  = expiry_q;
		mem_wtag = tag_q;
		rd_addr  = head_ptr_q;
		out_load = 1'b0;
		case (state_q)
			S_START: rd_addr = tail_idx;
			S_WALK: begin
				rd_addr = idx_dec(walk_idx_q);
				if (!cmp_le) begin
					mem_we   = 1'b1;
					mem_wa   = idx_inc(walk_idx_q);
					mem_wdl  = rd_dl_q;
					mem_wtag = rd_tag_q;
				end
			end
			S_PLACE: mem_we = 1'b1;
			S_CHECK: rd_addr = idx_inc(head_ptr_q);
			S_RES:   out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_dl[mem_wa]  <= mem_wdl;
			mem_tag[mem_wa] <= mem_wtag;
		end
		rd_dl_q  <= mem_dl[rd_addr];
		rd_tag_q <= mem_tag[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tick_now_q  <= '0;
			count_q     <= '0;
			head_ptr_q  <= '0;
			freq_q      <= FREQ_RESET;
			out_valid_q <= 1'b0;
			n_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				freq_q <= pwdata;
			end
			if (state_q == S_IDLE) begin
				n_q <= '0;
			end
			if (state_q == S_TICK) begin
				tick_now_q <= sum_w;
			end
			if ((state_q == S_CHECK) && (state_d == S_LOAD)) begin
				head_ptr_q <= idx_inc(head_ptr_q);
				count_q    <= count_q - 1'b1;
				n_q        <= n_q + 1'b1;
			end
			if (state_q == S_PLACE) begin
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					timeout_q <= timeout;
					tag_q     <= TAG_BITS'(event_tag);
					addend_q  <= 64'(timeout);
				end
			end
			S_MUL: addend_q <= mul_w;
			S_ADD: expiry_q <= sum_w;
			S_START: begin
				walk_idx_q <= tail_idx;
				place_q    <= head_ptr_q;
				res_kind_q <= KIND_FULL;
				res_tag_q  <= '0;
				res_time_q <= expiry_q;
			end
			S_WALK: begin
				if (cmp_le) begin
					place_q <= idx_inc(walk_idx_q);
				end else begin
					place_q    <= walk_idx_q;
					walk_idx_q <= idx_dec(walk_idx_q);
				end
			end
			S_PLACE: begin
				res_kind_q <= KIND_ADDED;
				if (place_q == head_ptr_q) begin
					head_dl_q  <= expiry_q;
					head_tag_q <= tag_q;
				end
			end
			S_CHECK: begin
				if (state_d == S_LOAD) begin
					res_kind_q <= KIND_FIRED;
					res_tag_q  <= head_tag_q;
					res_time_q <= head_dl_q;
				end else begin
					res_kind_q <= KIND_NONE;
					res_tag_q  <= '0;
					res_time_q <= '0;
				end
			end
			S_LOAD: begin
				head_dl_q  <= rd_dl_q;
				head_tag_q <= rd_tag_q;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_kind_q  <= res_kind_q;
			out_tag_q   <= 16'(res_tag_q);
			out_time_q  <= res_time_q;
			out_count_q <= 5'(count_q);
			out_dl_q    <= (count_q != '0) ? head_dl_q : '0;
			out_armed_q <= (count_q != '0);
			out_last_q  <= !cont;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_kind_q;
	assign fired_tag     = out_tag_q;
	assign fire_time     = out_time_q;
	assign queue_count   = out_count_q;
	assign next_deadline = out_dl_q;
	assign armed         = out_armed_q;
	assign last          = out_last_q;

endmodule

FILE: hw/rtl/steq_checker.sv
// Port-level checks of the sorted timer event queue, bound to its top level.
module steq_checker
	import steq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        kind,
	input logic [15:0]       fired_tag,
	input logic [63:0]       fire_time,
	input logic [4:0]        queue_count,
	input logic [63:0]       next_deadline,
	input logic              armed,
	input logic              last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fire_time) && $stable(kind)
			&& $stable(last))
		else $error("result changed while stalled");

	a_armed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (armed == (queue_count != 5'd0)))
		else $error("armed disagrees with count");

	a_idle_deadline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !armed |-> (next_deadline == 64'd0))
		else $error("deadline shown with empty queue");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((kind == KIND_NONE) || (kind == KIND_ADDED) || (kind == KIND_FULL))
			|-> last && (fired_tag == 16'd0))
		else $error("non-fired result not final or carries a tag");

endmodule

bind sorted_timer_event_queue steq_checker u_steq_checker (.*);
